// ===== hw/rtl/lfp_pkg.sv =====
// Shared types, codes and CRC helpers for the link frame parser.
`default_nettype none

package lfp_pkg;

    localparam int TICK_COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 8'd1;

    localparam logic [15:0] TIMEOUT_RESET     = 16'd200;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd255;
    localparam logic [15:0] CRC_SEED          = 16'hFFFF;
    localparam logic [7:0]  START_BYTE        = 8'hFD;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CRC      = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [1:0]  status;
        logic [23:0] message_id;
        logic [7:0]  sender_system;
        logic [7:0]  sender_component;
        logic [7:0]  sequence_res;
        logic [7:0]  frame_length;
    } result_t;

    // CRC-16/MCRF4XX, one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] extra_byte(input logic [23:0] id);
        case (id)
            24'd0:      return 8'd50;
            24'd1:      return 8'd124;
            24'd24:     return 8'd24;
            24'd30:     return 8'd39;
            24'd76:     return 8'd152;
            24'd77:     return 8'd143;
            24'd23:     return 8'd168;
            24'd150000: return 8'd190;
            24'd150001: return 8'd77;
            default:    return 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/link_frame_parser_crc16_top.sv =====
// A result word is registered into m_*, or parked in the skid stage while m_* is stalled.
// Takes one input word per cycle while s_ready; parser state and CRC update in one pass.
// A skid stage behind the output register keeps s_ready high while one result waits.
// s_ready drops only while the skid stage is full; cfg_ready is always high.
// Reset: synchronous, active-low aresetn; parser hunts for a start byte,
// timeout_ticks = 200, max_payload = 255, output and skid stages empty.
`default_nettype none

module link_frame_parser_crc16_top #(
    parameter int TICK_COUNT_BITS = lfp_pkg::TICK_COUNT_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lfp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [7:0]                     s_rx_byte,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_kind,
    output logic [7:0]                          m_payload_byte,
    output logic [7:0]                          m_payload_index,
    output logic [1:0]                          m_status,
    output logic [23:0]                         m_message_id,
    output logic [7:0]                          m_sender_system,
    output logic [7:0]                          m_sender_component,
    output logic [7:0]                          m_sequence_res,
    output logic [7:0]                          m_frame_length
);

    localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN     = 4'd1,
        PH_INCF    = 4'd2,
        PH_CMPF    = 4'd3,
        PH_SEQ     = 4'd4,
        PH_SYS     = 4'd5,
        PH_COMP    = 4'd6,
        PH_IDL     = 4'd7,
        PH_IDM     = 4'd8,
        PH_IDH     = 4'd9,
        PH_PAYLOAD = 4'd10,
        PH_CRCL    = 4'd11,
        PH_CRCH    = 4'd12
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [15:0]                crc_reg, crc_next;
    logic [7:0]                 len_reg, len_next;
    logic [7:0]                 index_reg, index_next;
    logic [23:0]                msg_id_reg, msg_id_next;
    logic [7:0]                 seq_reg, seq_next;
    logic [7:0]                 sys_reg, sys_next;
    logic [7:0]                 comp_reg, comp_next;
    logic [TICK_COUNT_BITS-1:0] elapsed_reg, elapsed_next;
    logic [15:0]                timeout_reg;
    logic [7:0]                 max_payload_reg;

    lfp_pkg::result_t           res_next;
    logic                       res_valid;
    lfp_pkg::result_t           m_res_reg, skid_res_reg;
    logic                       m_valid_reg, skid_valid_reg;

    logic                       in_accept, cfg_accept, out_free;
    logic [TICK_COUNT_BITS-1:0] elapsed_inc;
    logic [8:0]                 index_inc;
    logic [15:0]                crc_byte;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !skid_valid_reg;
    assign in_accept  = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_valid_reg || m_ready;

    assign elapsed_inc = (elapsed_reg == {TICK_COUNT_BITS{1'b1}}) ?
                         elapsed_reg : elapsed_reg + TICK_COUNT_BITS'(1);
    assign index_inc   = {1'b0, index_reg} + 9'd1;
    assign crc_byte    = lfp_pkg::crc_fold(crc_reg, s_rx_byte);

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        len_next     = len_reg;
        index_next   = index_reg;
        msg_id_next  = msg_id_reg;
        seq_next     = seq_reg;
        sys_next     = sys_reg;
        comp_next    = comp_reg;
        elapsed_next = elapsed_reg;
        res_valid    = 1'b0;
        res_next.kind          = lfp_pkg::KIND_REPORT;
        res_next.payload_byte  = 8'd0;
        res_next.payload_index = 8'd0;
        res_next.status        = lfp_pkg::ST_GOOD;

        if (s_op == lfp_pkg::OP_TICK) begin
            if (phase_reg == PH_HUNT || phase_reg > PH_CRCH) begin
                phase_next = PH_HUNT;
            end else begin
                elapsed_next = elapsed_inc;
                if (CMP_W'(elapsed_inc) > CMP_W'(timeout_reg)) begin
                    res_valid       = 1'b1;
                    res_next.status = lfp_pkg::ST_TIMEOUT;
                    phase_next      = PH_HUNT;
                end
            end
        end else begin
            case (phase_reg)
                PH_LEN: begin
                    len_next   = s_rx_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_INCF;
                end
                PH_INCF: begin
                    crc_next   = crc_byte;
                    phase_next = PH_CMPF;
                end
                PH_CMPF: begin
                    crc_next   = crc_byte;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = s_rx_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_SYS;
                end
                PH_SYS: begin
                    sys_next   = s_rx_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_COMP;
                end
                PH_COMP: begin
                    comp_next  = s_rx_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_IDL;
                end
                PH_IDL: begin
                    msg_id_next = {16'h0000, s_rx_byte};
                    crc_next    = crc_byte;
                    phase_next  = PH_IDM;
                end
                PH_IDM: begin
                    msg_id_next = {8'h00, s_rx_byte, msg_id_reg[7:0]};
                    crc_next    = crc_byte;
                    phase_next  = PH_IDH;
                end
                PH_IDH: begin
                    msg_id_next = {s_rx_byte, msg_id_reg[15:0]};
                    crc_next    = crc_byte;
                    index_next  = 8'd0;
                    if (len_reg == 8'd0) begin
                        // empty payload: fold the extra byte right after the header
                        crc_next   = lfp_pkg::crc_fold(crc_byte,
                                         lfp_pkg::extra_byte(msg_id_next));
                        phase_next = PH_CRCL;
                    end else if (len_reg > max_payload_reg) begin
                        res_valid       = 1'b1;
                        res_next.status = lfp_pkg::ST_OVERSIZE;
                        phase_next      = PH_HUNT;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid              = 1'b1;
                    res_next.kind          = lfp_pkg::KIND_PAYLOAD;
                    res_next.payload_byte  = s_rx_byte;
                    res_next.payload_index = index_reg;
                    crc_next               = crc_byte;
                    index_next             = index_inc[7:0];
                    if (index_inc >= {1'b0, len_reg}) begin
                        crc_next   = lfp_pkg::crc_fold(crc_byte,
                                         lfp_pkg::extra_byte(msg_id_reg));
                        phase_next = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    if (s_rx_byte == crc_reg[7:0]) begin
                        phase_next = PH_CRCH;
                    end else begin
                        res_valid       = 1'b1;
                        res_next.status = lfp_pkg::ST_CRC;
                        phase_next      = PH_HUNT;
                    end
                end
                PH_CRCH: begin
                    res_valid       = 1'b1;
                    res_next.status = (s_rx_byte == crc_reg[15:8]) ?
                                      lfp_pkg::ST_GOOD : lfp_pkg::ST_CRC;
                    phase_next      = PH_HUNT;
                end
                default: begin
                    // hunt; unused codes behave the same
                    phase_next = PH_HUNT;
                    if (s_rx_byte == lfp_pkg::START_BYTE) begin
                        crc_next     = lfp_pkg::CRC_SEED;
                        len_next     = 8'd0;
                        index_next   = 8'd0;
                        msg_id_next  = 24'd0;
                        seq_next     = 8'd0;
                        sys_next     = 8'd0;
                        comp_next    = 8'd0;
                        elapsed_next = '0;
                        phase_next   = PH_LEN;
                    end
                end
            endcase
        end

        res_next.message_id       = msg_id_next;
        res_next.sender_system    = sys_next;
        res_next.sender_component = comp_next;
        res_next.sequence_res     = seq_next;
        res_next.frame_length     = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            crc_reg         <= lfp_pkg::CRC_SEED;
            len_reg         <= 8'd0;
            index_reg       <= 8'd0;
            msg_id_reg      <= 24'd0;
            seq_reg         <= 8'd0;
            sys_reg         <= 8'd0;
            comp_reg        <= 8'd0;
            elapsed_reg     <= '0;
            timeout_reg     <= lfp_pkg::TIMEOUT_RESET;
            max_payload_reg <= lfp_pkg::MAX_PAYLOAD_RESET;
            m_valid_reg     <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (cfg_index)
                    lfp_pkg::CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
                    lfp_pkg::CFG_MAX_PAYLOAD:   max_payload_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                phase_reg   <= phase_next;
                crc_reg     <= crc_next;
                len_reg     <= len_next;
                index_reg   <= index_next;
                msg_id_reg  <= msg_id_next;
                seq_reg     <= seq_next;
                sys_reg     <= sys_next;
                comp_reg    <= comp_next;
                elapsed_reg <= elapsed_next;
            end

            // drain skid first; park a new word in the skid while m_* is stalled
            if (out_free) begin
                if (skid_valid_reg) begin
                    m_res_reg      <= skid_res_reg;
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (in_accept && res_valid) begin
                    m_res_reg   <= res_next;
                    m_valid_reg <= 1'b1;
                end else begin
                    m_valid_reg <= 1'b0;
                end
            end else if (in_accept && res_valid) begin
                skid_res_reg   <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = m_res_reg.kind;
    assign m_payload_byte     = m_res_reg.payload_byte;
    assign m_payload_index    = m_res_reg.payload_index;
    assign m_status           = m_res_reg.status;
    assign m_message_id       = m_res_reg.message_id;
    assign m_sender_system    = m_res_reg.sender_system;
    assign m_sender_component = m_res_reg.sender_component;
    assign m_sequence_res     = m_res_reg.sequence_res;
    assign m_frame_length     = m_res_reg.frame_length;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held with empty output register");

    a_start_seeds_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_op == lfp_pkg::OP_BYTE && phase_reg == PH_HUNT &&
         s_rx_byte == lfp_pkg::START_BYTE)
        |=> (phase_reg == PH_LEN && crc_reg == lfp_pkg::CRC_SEED && elapsed_reg == '0))
        else $error("start byte did not open a fresh frame");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> index_reg < len_reg)
        else $error("payload index ran past frame length");

    a_payload_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == lfp_pkg::KIND_PAYLOAD)
        |-> (m_status == lfp_pkg::ST_GOOD && m_payload_index < m_frame_length))
        else $error("malformed payload word");

endmodule

`default_nettype wire
